/* sv/dsg_pkg.sv */
// Shared types and constants for the diagnostic service security gate.
// Item structs, service and response codes, and the queue entry format.
// No dependencies.
package dsg_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0]  SID_TESTER_PRESENT  = 8'h3E;
    localparam logic [7:0]  SID_SECURITY_ACCESS = 8'h27;
    localparam logic [7:0]  SID_READ_BY_ID      = 8'h22;
    localparam logic [7:0]  SID_WRITE_BY_ID     = 8'h2E;
    localparam logic [7:0]  NEG_RESPONSE        = 8'h7F;
    localparam logic [7:0]  POS_OFFSET          = 8'h40;
    localparam logic [7:0]  SUB_REQUEST_SEED    = 8'h01;
    localparam logic [7:0]  SUB_SEND_KEY        = 8'h02;

    localparam logic [7:0]  NRC_NOT_SUPPORTED     = 8'h11;
    localparam logic [7:0]  NRC_SUB_NOT_SUPPORTED = 8'h12;
    localparam logic [7:0]  NRC_ACCESS_DENIED     = 8'h33;
    localparam logic [7:0]  NRC_INVALID_KEY       = 8'h35;
    localparam logic [7:0]  NRC_EXCEEDED          = 8'h36;
    localparam logic [7:0]  NRC_TIME_DELAY        = 8'h37;

    localparam logic [12:0] MAX_REQUEST_LEN = 13'd4096;
    localparam logic [3:0]  FAIL_SAT        = 4'd15;

    localparam logic [1:0]  CFG_SECRET_WORD   = 2'd0;
    localparam logic [1:0]  CFG_LOCKOUT_TICKS = 2'd1;
    localparam logic [1:0]  CFG_MAX_ATTEMPTS  = 2'd2;

    localparam logic [63:0] SECRET_RESET   = 64'h1122334455667788;
    localparam logic [31:0] LOCKOUT_RESET  = 32'd10000000;
    localparam logic [3:0]  ATTEMPTS_RESET = 4'd3;

    typedef struct packed {
        logic        command;
        logic [7:0]  service_id;
        logic [12:0] request_length;
        logic [7:0]  param_byte;
        logic [63:0] body_bytes;
        logic [63:0] fresh_seed;
    } in_item_t;

    typedef struct packed {
        logic [3:0]  resp_length;
        logic [7:0]  resp_byte0;
        logic [7:0]  resp_byte1;
        logic [7:0]  resp_byte2;
        logic [63:0] resp_seed;
    } out_item_t;

    typedef enum logic [2:0] {
        OP_TICK,
        OP_TESTER,
        OP_SA_NOSUB,
        OP_SEED,
        OP_KEY,
        OP_ID,
        OP_OTHER
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [7:0]  sid;
        logic [7:0]  p1;
        logic [7:0]  p2;
        logic        len_ge2;
        logic        len_ge10;
        logic [63:0] data;
    } q_entry_t;

endpackage

/* sv/dsg_front.sv */
// Front end: accepts items and classifies them into queue entries.
// Drops requests of illegal length. Depends on dsg_pkg.
module dsg_front (
    input  logic              s_valid,
    output logic              s_ready,
    input  dsg_pkg::in_item_t s_item,
    input  logic              q_full,
    output logic              q_wr,
    output dsg_pkg::q_entry_t q_entry
);
    import dsg_pkg::*;

    logic len_ok;
    logic len_ge2;
    logic len_ge3;

    assign s_ready = !q_full;
    assign len_ge2 = s_item.request_length >= 13'd2;
    assign len_ge3 = s_item.request_length >= 13'd3;
    assign len_ok  = (s_item.request_length != 13'd0) &&
                     (s_item.request_length <= MAX_REQUEST_LEN);
    assign q_wr    = s_valid && s_ready && (s_item.command || len_ok);

    always_comb begin
        q_entry.sid      = s_item.service_id;
        q_entry.p1       = len_ge2 ? s_item.param_byte : 8'h00;
        q_entry.p2       = len_ge3 ? s_item.body_bytes[63:56] : 8'h00;
        q_entry.len_ge2  = len_ge2;
        q_entry.len_ge10 = s_item.request_length >= 13'd10;
        q_entry.data     = s_item.body_bytes;
        q_entry.op       = OP_OTHER;
        if (s_item.command) begin
            q_entry.op = OP_TICK;
        end else if (s_item.service_id == SID_TESTER_PRESENT) begin
            q_entry.op = OP_TESTER;
        end else if (s_item.service_id == SID_SECURITY_ACCESS) begin
            if (!len_ge2) begin
                q_entry.op = OP_SA_NOSUB;
            end else if (s_item.param_byte == SUB_REQUEST_SEED) begin
                q_entry.op   = OP_SEED;
                q_entry.data = s_item.fresh_seed;
            end else if (s_item.param_byte == SUB_SEND_KEY) begin
                q_entry.op = OP_KEY;
            end else begin
                q_entry.op = OP_SA_NOSUB;
            end
        end else if (s_item.service_id == SID_READ_BY_ID ||
                     s_item.service_id == SID_WRITE_BY_ID) begin
            q_entry.op = OP_ID;
        end
    end

endmodule

/* sv/dsg_queue.sv */
// Short FIFO of classified entries between front and back.
// Depends on dsg_pkg.
module dsg_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              wr,
    input  dsg_pkg::q_entry_t wr_entry,
    input  logic              rd,
    output logic              q_valid,
    output logic              q_full,
    output dsg_pkg::q_entry_t head
);
    import dsg_pkg::*;

    q_entry_t          mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign q_valid = count_reg != '0;
    assign q_full  = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign head    = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr && !rd) begin
            count_next = count_reg + 1'b1;
        end else if (rd && !wr) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr) begin
            mem[wr_ptr_reg] <= wr_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count overflow");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (wr && !rd) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue push lost");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree when empty");

endmodule

/* sv/dsg_back.sv */
// Back end: security state, configuration registers and response register.
// Executes one queue entry per cycle unless a held response stalls a non-tick entry. Depends on dsg_pkg.
module dsg_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_valid,
    input  dsg_pkg::q_entry_t  head,
    output logic               q_rd,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [63:0]        cfg_data,
    output logic               m_valid,
    input  logic               m_ready,
    output dsg_pkg::out_item_t m_item
);
    import dsg_pkg::*;

    logic [63:0] secret_reg;
    logic [31:0] lockout_ticks_reg;
    logic [3:0]  max_attempts_reg;

    logic        unlocked_reg, unlocked_next;
    logic [63:0] seed_reg, seed_next;
    logic [3:0]  fail_reg, fail_next;
    logic        lock_active_reg, lock_active_next;
    logic [31:0] elapsed_reg, elapsed_next;

    logic        m_valid_reg, m_valid_next;
    out_item_t   m_item_reg, m_item_next;

    logic        in_force;
    logic        key_match;
    logic [3:0]  fail_inc;
    logic        emit;
    out_item_t   resp;

    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_item    = m_item_reg;

    assign q_rd      = q_valid && (head.op == OP_TICK || !m_valid_reg || m_ready);
    assign in_force  = lock_active_reg && (elapsed_reg < lockout_ticks_reg);
    assign key_match = head.data == (seed_reg ^ secret_reg);
    assign fail_inc  = (fail_reg < FAIL_SAT) ? fail_reg + 4'd1 : fail_reg;

    always_comb begin
        unlocked_next    = unlocked_reg;
        seed_next        = seed_reg;
        fail_next        = fail_reg;
        lock_active_next = lock_active_reg;
        elapsed_next     = elapsed_reg;
        emit             = 1'b1;
        resp.resp_length = 4'd3;
        resp.resp_byte0  = NEG_RESPONSE;
        resp.resp_byte1  = head.sid;
        resp.resp_byte2  = NRC_NOT_SUPPORTED;
        resp.resp_seed   = '0;
        unique case (head.op)
            OP_TICK: begin
                emit = 1'b0;
                if (lock_active_reg && elapsed_reg != '1) begin
                    elapsed_next = elapsed_reg + 32'd1;
                end
            end
            OP_TESTER: begin
                resp.resp_length = head.len_ge2 ? 4'd2 : 4'd1;
                resp.resp_byte0  = head.sid + POS_OFFSET;
                resp.resp_byte1  = head.p1;
                resp.resp_byte2  = 8'h00;
            end
            OP_SA_NOSUB: begin
                resp.resp_byte2 = NRC_SUB_NOT_SUPPORTED;
            end
            OP_SEED: begin
                if (in_force) begin
                    resp.resp_byte2 = NRC_TIME_DELAY;
                end else begin
                    lock_active_next = 1'b0;
                    elapsed_next     = '0;
                    seed_next        = head.data;
                    resp.resp_length = 4'd10;
                    resp.resp_byte0  = head.sid + POS_OFFSET;
                    resp.resp_byte1  = head.p1;
                    resp.resp_byte2  = 8'h00;
                    resp.resp_seed   = head.data;
                end
            end
            OP_KEY: begin
                if (in_force) begin
                    resp.resp_byte2 = NRC_TIME_DELAY;
                end else if (!head.len_ge10) begin
                    resp.resp_byte2 = NRC_INVALID_KEY;
                end else if (key_match) begin
                    unlocked_next    = 1'b1;
                    fail_next        = '0;
                    resp.resp_length = 4'd2;
                    resp.resp_byte0  = head.sid + POS_OFFSET;
                    resp.resp_byte1  = head.p1;
                    resp.resp_byte2  = 8'h00;
                end else begin
                    fail_next = fail_inc;
                    if (fail_inc >= max_attempts_reg) begin
                        lock_active_next = 1'b1;
                        elapsed_next     = '0;
                        resp.resp_byte2  = NRC_EXCEEDED;
                    end else begin
                        resp.resp_byte2 = NRC_INVALID_KEY;
                    end
                end
            end
            OP_ID: begin
                if (!unlocked_reg) begin
                    resp.resp_byte2 = NRC_ACCESS_DENIED;
                end else begin
                    resp.resp_byte0 = head.sid + POS_OFFSET;
                    resp.resp_byte1 = head.p1;
                    resp.resp_byte2 = head.p2;
                end
            end
            OP_OTHER: begin
                resp.resp_byte2 = NRC_NOT_SUPPORTED;
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        m_item_next  = m_item_reg;
        if (q_rd && emit) begin
            m_valid_next = 1'b1;
            m_item_next  = resp;
        end
    end

    always_ff @(posedge aclk) begin
        m_item_reg <= m_item_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            secret_reg        <= SECRET_RESET;
            lockout_ticks_reg <= LOCKOUT_RESET;
            max_attempts_reg  <= ATTEMPTS_RESET;
            unlocked_reg      <= 1'b0;
            seed_reg          <= '0;
            fail_reg          <= '0;
            lock_active_reg   <= 1'b0;
            elapsed_reg       <= '0;
            m_valid_reg       <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    CFG_SECRET_WORD:   secret_reg        <= cfg_data;
                    CFG_LOCKOUT_TICKS: lockout_ticks_reg <= cfg_data[31:0];
                    CFG_MAX_ATTEMPTS:  max_attempts_reg  <= cfg_data[3:0];
                    default: ;
                endcase
            end
            if (q_rd) begin
                unlocked_reg    <= unlocked_next;
                seed_reg        <= seed_next;
                fail_reg        <= fail_next;
                lock_active_reg <= lock_active_next;
                elapsed_reg     <= elapsed_next;
            end
            m_valid_reg <= m_valid_next;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        (q_rd && head.op == OP_SEED && !in_force) |=> !lock_active_reg)
        else $error("seed grant left lockout active");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (q_rd && head.op == OP_KEY && !in_force && head.len_ge10 && key_match)
        |=> (unlocked_reg && fail_reg == '0))
        else $error("matching key did not unlock");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (q_rd && head.op == OP_TICK && !m_valid_reg) |=> !m_valid_reg)
        else $error("tick produced a response");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (q_valid && head.op != OP_TICK && m_valid_reg && !m_ready) |-> !q_rd)
        else $error("response overwritten while stalled");

endmodule

/* sv/diag_service_security_gate.sv */
// Diagnostic service security gate: seed/key unlock with failed-key lockout.
// An accepted request is written into the queue, then executed into the registered response.
// Throughput: one item per cycle, set by the single-entry execute step in the back end, while no response is held.
// Ticks and dropped requests give no response; a full 2-entry queue drops s_ready.
// Synchronous active-low reset clears the security state and restores register defaults.
// Depends on dsg_pkg, dsg_front, dsg_queue and dsg_back.
module diag_service_security_gate (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  dsg_pkg::in_item_t  s_item,
    output logic               m_valid,
    input  logic               m_ready,
    output dsg_pkg::out_item_t m_item,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [63:0]        cfg_data
);
    import dsg_pkg::*;

    logic     q_wr;
    logic     q_rd;
    logic     q_valid;
    logic     q_full;
    q_entry_t wr_entry;
    q_entry_t head;

    dsg_front u_front (
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .q_full  (q_full),
        .q_wr    (q_wr),
        .q_entry (wr_entry)
    );

    dsg_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr       (q_wr),
        .wr_entry (wr_entry),
        .rd       (q_rd),
        .q_valid  (q_valid),
        .q_full   (q_full),
        .head     (head)
    );

    dsg_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .head      (head),
        .q_rd      (q_rd),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

endmodule
